/* rtl/kfi_pkg.sv */
// Shared types and constants of the keyframe linear interpolator.
// Used by every module of the block; depends on nothing else.

package kfi_pkg;

   // Keyframe store geometry.
   localparam int FRAME_DEPTH = 256;
   localparam int FRAME_AW    = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

   // Channel layout: x, y, z position, rotation about y, rotation about z.
   localparam int NUM_CHAN = 5;
   localparam int CH_W     = $clog2(NUM_CHAN);
   localparam int CH_X     = 0;
   localparam int CH_Y     = 1;
   localparam int CH_Z     = 2;
   localparam int CH_AY    = 3;
   localparam int CH_AZ    = 4;

   localparam int CHAN_W  = 32;
   localparam int STEPS_W = 16;
   localparam int COUNT_W = 9;
   localparam int SEG_W   = 8;
   localparam int SLOT_W  = 8;

   typedef logic signed [CHAN_W-1:0]  chan_type;
   typedef chan_type    [NUM_CHAN-1:0] chan_vec_type;
   typedef logic        [FRAME_AW-1:0] addr_type;
   typedef logic        [COUNT_W-1:0]  count_type;
   typedef logic        [SEG_W-1:0]    seg_type;
   typedef logic        [STEPS_W-1:0]  steps_type;
   typedef logic        [CH_W-1:0]     ch_type;

   localparam steps_type STEPS_RESET = steps_type'(30);

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef struct packed {
      op_type                   operation;
      logic [SLOT_W-1:0]        frame_slot;
      logic signed [CHAN_W-1:0] key_pos_x;
      logic signed [CHAN_W-1:0] key_pos_y;
      logic signed [CHAN_W-1:0] key_pos_z;
      logic signed [CHAN_W-1:0] key_angle_y;
      logic signed [CHAN_W-1:0] key_angle_z;
   } req_type;

   typedef struct packed {
      logic signed [CHAN_W-1:0] cur_x;
      logic signed [CHAN_W-1:0] cur_y;
      logic signed [CHAN_W-1:0] cur_z;
      logic signed [CHAN_W-1:0] cur_angle_y;
      logic signed [CHAN_W-1:0] cur_angle_z;
      logic                     playing;
      logic [SEG_W-1:0]         segment;
      logic                     finished;
   } rsp_type;

   // Keyframe store port: one write and one read address per cycle.
   typedef struct packed {
      logic         wr_en;
      addr_type     wr_addr;
      chan_vec_type wr_data;
      logic         rd_en;
      addr_type     rd_addr;
   } ram_cmd_type;

   // Divider command and status.
   typedef struct packed {
      logic                   start;
      logic signed [CHAN_W:0] dividend;
      steps_type              divisor;
   } div_cmd_type;

   typedef struct packed {
      logic     done;
      chan_type quotient;
   } div_rsp_type;

endpackage

/* rtl/keyframe_linear_interpolator.sv */
// Top level of the keyframe linear interpolator.
// Depends on kfi_pkg, kfi_frame_ram and kfi_divider.

// Every accepted item yields exactly one result transfer that reports the
// five current channel values, the play flag, the segment index and whether
// this item ended the animation. The block takes one item at a time: req_stall
// is low only while the controller waits for a new item. Loads, stops, idle
// ticks, plain interpolation ticks and the idle code go from accept straight
// to S_EMIT, which writes the result register. A start from idle and a tick
// that moves to the next segment first read the keyframe memory twice and
// then wait for the five per-step increments, which come one after the other
// from a single bit-serial divider that retires one quotient bit per cycle
// (33 quotient bits, plus setup and saturation). A result that waits
// in the output register does not stop the next item from being accepted and
// worked on; only the next result write waits for it. The keyframe memory
// is not cleared after reset, so reading a slot that was never loaded gives
// an arbitrary value. The step register is written through the csr_ port,
// which is always ready, and should only be written while no item is in flight.

module keyframe_linear_interpolator (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  kfi_pkg::req_type            req_data,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output kfi_pkg::rsp_type            rsp_data,

   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [kfi_pkg::STEPS_W-1:0] csr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ_B,
      S_DIV_GO,
      S_DIV_WAIT,
      S_EMIT
   } ctl_state_type;

   localparam kfi_pkg::chan_type SAT_MAX = {1'b0, {(kfi_pkg::CHAN_W - 1){1'b1}}};
   localparam kfi_pkg::chan_type SAT_MIN = {1'b1, {(kfi_pkg::CHAN_W - 1){1'b0}}};

   // Add with saturation to the signed 32-bit range.
   function automatic kfi_pkg::chan_type sat_add(kfi_pkg::chan_type a,
                                                 kfi_pkg::chan_type b);
      logic signed [kfi_pkg::CHAN_W:0] sum;
      begin
         sum = {a[kfi_pkg::CHAN_W-1], a} + {b[kfi_pkg::CHAN_W-1], b};
         if (sum[kfi_pkg::CHAN_W] != sum[kfi_pkg::CHAN_W-1]) begin
            return sum[kfi_pkg::CHAN_W] ? SAT_MIN : SAT_MAX;
         end
         return sum[kfi_pkg::CHAN_W-1:0];
      end
   endfunction

   // Controller state.
   ctl_state_type         state_ff, state_in;
   kfi_pkg::count_type    frame_count_ff, frame_count_in;
   logic                  play_ff, play_in;
   kfi_pkg::seg_type      seg_ff, seg_in;
   kfi_pkg::steps_type    step_ff, step_in;
   kfi_pkg::steps_type    steps_ff, steps_in;
   kfi_pkg::chan_vec_type inc_ff, inc_in;
   kfi_pkg::chan_vec_type cur_ff, cur_in;
   logic                  finished_ff, finished_in;
   logic                  is_start_ff, is_start_in;
   kfi_pkg::ch_type       ch_ff, ch_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   kfi_pkg::chan_vec_type frame_a_ff, frame_a_in;
   kfi_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   // Memory and divider connections.
   kfi_pkg::ram_cmd_type  ram_cmd;
   kfi_pkg::chan_vec_type ram_rd_data;
   kfi_pkg::div_cmd_type  div_cmd;
   kfi_pkg::div_rsp_type  div_rsp;

   logic                  accept;
   logic                  out_free;
   logic                  slot_ok;
   logic                  last_segment;
   kfi_pkg::chan_type     frame_b_ch;
   kfi_pkg::chan_type     frame_a_ch;

   kfi_frame_ram u_frame_ram (
      .clock   (clock),
      .cmd     (ram_cmd),
      .rd_data (ram_rd_data)
   );

   kfi_divider u_divider (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // The output register can take a new result when empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign slot_ok   = int'(req_data.frame_slot) < kfi_pkg::FRAME_DEPTH;

   // The animation ends when the segment after this one has no end frame.
   assign last_segment = (kfi_pkg::count_type'(seg_ff) + kfi_pkg::count_type'(1)
                          + kfi_pkg::count_type'(2)) > frame_count_ff;

   // The segment's end frame stays on the memory's read port while dividing.
   assign frame_b_ch = ram_rd_data[ch_ff];
   assign frame_a_ch = frame_a_ff[ch_ff];

   always_comb begin
      state_in       = state_ff;
      frame_count_in = frame_count_ff;
      play_in        = play_ff;
      seg_in         = seg_ff;
      step_in        = step_ff;
      steps_in       = steps_ff;
      inc_in         = inc_ff;
      cur_in         = cur_ff;
      finished_in    = finished_ff;
      is_start_in    = is_start_ff;
      ch_in          = ch_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      frame_a_in     = frame_a_ff;
      rsp_data_in    = rsp_data_ff;

      ram_cmd.wr_en                    = 1'b0;
      ram_cmd.wr_addr                  = kfi_pkg::addr_type'(req_data.frame_slot);
      ram_cmd.wr_data[kfi_pkg::CH_X]   = req_data.key_pos_x;
      ram_cmd.wr_data[kfi_pkg::CH_Y]   = req_data.key_pos_y;
      ram_cmd.wr_data[kfi_pkg::CH_Z]   = req_data.key_pos_z;
      ram_cmd.wr_data[kfi_pkg::CH_AY]  = req_data.key_angle_y;
      ram_cmd.wr_data[kfi_pkg::CH_AZ]  = req_data.key_angle_z;
      ram_cmd.rd_en                    = 1'b0;
      ram_cmd.rd_addr                  = kfi_pkg::addr_type'(seg_ff) + 1'b1;

      div_cmd.start    = 1'b0;
      div_cmd.dividend = {frame_b_ch[kfi_pkg::CHAN_W-1], frame_b_ch}
                       - {frame_a_ch[kfi_pkg::CHAN_W-1], frame_a_ch};
      div_cmd.divisor  = steps_ff;

      if (csr_valid && csr_ready) begin
         steps_in = csr_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               finished_in = 1'b0;
               state_in    = S_EMIT;
               unique case (req_data.operation)
                  kfi_pkg::OP_LOAD: begin
                     if (slot_ok) begin
                        ram_cmd.wr_en  = 1'b1;
                        frame_count_in = kfi_pkg::count_type'(req_data.frame_slot)
                                       + kfi_pkg::count_type'(1);
                     end
                  end
                  kfi_pkg::OP_START: begin
                     if (!play_ff && frame_count_ff > kfi_pkg::count_type'(1)) begin
                        // Start from frame 0: read it now, frame 1 next cycle.
                        seg_in          = '0;
                        step_in         = '0;
                        play_in         = 1'b1;
                        is_start_in     = 1'b1;
                        ram_cmd.rd_en   = 1'b1;
                        ram_cmd.rd_addr = '0;
                        state_in        = S_READ_B;
                     end else begin
                        play_in = 1'b0;
                     end
                  end
                  kfi_pkg::OP_TICK: begin
                     if (play_ff) begin
                        if (step_ff >= steps_ff) begin
                           if (last_segment) begin
                              seg_in      = '0;
                              play_in     = 1'b0;
                              finished_in = 1'b1;
                           end else begin
                              seg_in          = seg_ff + 1'b1;
                              step_in         = '0;
                              is_start_in     = 1'b0;
                              ram_cmd.rd_en   = 1'b1;
                              ram_cmd.rd_addr = kfi_pkg::addr_type'(seg_ff) + 1'b1;
                              state_in        = S_READ_B;
                           end
                        end else begin
                           for (int i = 0; i < kfi_pkg::NUM_CHAN; i++) begin
                              cur_in[i] = sat_add(cur_ff[i], inc_ff[i]);
                           end
                           step_in = step_ff + 1'b1;
                        end
                     end
                  end
                  kfi_pkg::OP_NONE: begin
                  end
               endcase
            end
         end
         S_READ_B: begin
            // Start frame arrives now; fetch the segment's end frame.
            ram_cmd.rd_en   = 1'b1;
            ram_cmd.rd_addr = kfi_pkg::addr_type'(seg_ff) + 1'b1;
            frame_a_in      = ram_rd_data;
            if (is_start_ff) begin
               cur_in = ram_rd_data;
            end
            ch_in    = '0;
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            div_cmd.start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               inc_in[ch_ff] = div_rsp.quotient;
               if (ch_ff == kfi_pkg::ch_type'(kfi_pkg::NUM_CHAN - 1)) begin
                  state_in = S_EMIT;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  state_in = S_DIV_GO;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.cur_x       = cur_ff[kfi_pkg::CH_X];
               rsp_data_in.cur_y       = cur_ff[kfi_pkg::CH_Y];
               rsp_data_in.cur_z       = cur_ff[kfi_pkg::CH_Z];
               rsp_data_in.cur_angle_y = cur_ff[kfi_pkg::CH_AY];
               rsp_data_in.cur_angle_z = cur_ff[kfi_pkg::CH_AZ];
               rsp_data_in.playing     = play_ff;
               rsp_data_in.segment     = seg_ff;
               rsp_data_in.finished    = finished_ff;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         frame_count_ff <= '0;
         play_ff        <= 1'b0;
         seg_ff         <= '0;
         step_ff        <= '0;
         steps_ff       <= kfi_pkg::STEPS_RESET;
         inc_ff         <= '0;
         cur_ff         <= '0;
         finished_ff    <= 1'b0;
         is_start_ff    <= 1'b0;
         ch_ff          <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frame_count_ff <= frame_count_in;
         play_ff        <= play_in;
         seg_ff         <= seg_in;
         step_ff        <= step_in;
         steps_ff       <= steps_in;
         inc_ff         <= inc_in;
         cur_ff         <= cur_in;
         finished_ff    <= finished_in;
         is_start_ff    <= is_start_in;
         ch_ff          <= ch_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      frame_a_ff  <= frame_a_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_finish_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.finished |-> !rsp_data.playing && rsp_data.segment == '0)
      else $error("finished result still reports playback");

   a_ram_single_access: assert property (@(posedge clock) disable iff (reset)
      ram_cmd.wr_en |-> !ram_cmd.rd_en)
      else $error("keyframe memory written and read in the same cycle");

   a_one_item_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted before the first finished");
`endif

endmodule

/* rtl/kfi_frame_ram.sv */
// Keyframe store: one synchronous memory holding all five channels of a frame.
// Depends on kfi_pkg for the address and frame types.

module kfi_frame_ram (
   input  logic                  clock,
   input  kfi_pkg::ram_cmd_type  cmd,
   output kfi_pkg::chan_vec_type rd_data
);

   kfi_pkg::chan_vec_type mem [kfi_pkg::FRAME_DEPTH];
   kfi_pkg::chan_vec_type rd_data_ff;

   // Read data holds its value until the next read is issued.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/kfi_divider.sv */
// Bit-serial signed divider: 33-bit dividend over 16-bit unsigned divisor,
// truncating toward zero and saturating to 32 bits. Depends on kfi_pkg.

module kfi_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  kfi_pkg::div_cmd_type cmd,
   output kfi_pkg::div_rsp_type rsp
);

   localparam int QUO_W = kfi_pkg::CHAN_W + 1;
   localparam int CNT_W = $clog2(QUO_W + 1);
   localparam int REM_W = kfi_pkg::STEPS_W;

   localparam logic [QUO_W-1:0] POS_LIMIT = {2'b00, {(kfi_pkg::CHAN_W - 1){1'b1}}};
   localparam logic [QUO_W-1:0] NEG_LIMIT = {2'b01, {(kfi_pkg::CHAN_W - 1){1'b0}}};
   localparam kfi_pkg::chan_type SAT_MAX  = {1'b0, {(kfi_pkg::CHAN_W - 1){1'b1}}};
   localparam kfi_pkg::chan_type SAT_MIN  = {1'b1, {(kfi_pkg::CHAN_W - 1){1'b0}}};

   typedef enum logic [1:0] {
      D_IDLE,
      D_RUN,
      D_FIX
   } div_state_type;

   div_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   kfi_pkg::steps_type divisor_ff, divisor_in;
   logic               neg_ff, neg_in;
   logic               done_ff, done_in;
   kfi_pkg::chan_type  quotient_ff, quotient_in;

   logic [REM_W:0] rem_shift;
   logic [REM_W:0] trial;
   logic           fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[QUO_W-1]};
      trial     = rem_shift - {1'b0, divisor_ff};
      fits      = (rem_shift >= {1'b0, divisor_ff});

      state_in    = state_ff;
      cnt_in      = cnt_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      divisor_in  = divisor_ff;
      neg_in      = neg_ff;
      done_in     = 1'b0;
      quotient_in = quotient_ff;

      unique case (state_ff)
         D_IDLE: begin
            if (cmd.start) begin
               neg_in     = cmd.dividend[QUO_W-1];
               quo_in     = cmd.dividend[QUO_W-1] ? QUO_W'(-cmd.dividend)
                                                  : QUO_W'(cmd.dividend);
               rem_in     = '0;
               cnt_in     = '0;
               divisor_in = cmd.divisor;
               if (cmd.divisor == '0) begin
                  // A zero step setting yields a zero increment.
                  quo_in   = '0;
                  neg_in   = 1'b0;
                  state_in = D_FIX;
               end else begin
                  state_in = D_RUN;
               end
            end
         end
         D_RUN: begin
            rem_in = fits ? trial[REM_W-1:0] : rem_shift[REM_W-1:0];
            quo_in = {quo_ff[QUO_W-2:0], fits};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUO_W - 1)) begin
               state_in = D_FIX;
            end
         end
         D_FIX: begin
            if (!neg_ff) begin
               quotient_in = (quo_ff > POS_LIMIT) ? SAT_MAX
                                                  : kfi_pkg::chan_type'(quo_ff[QUO_W-2:0]);
            end else begin
               quotient_in = (quo_ff > NEG_LIMIT) ? SAT_MIN
                                                  : kfi_pkg::chan_type'(-quo_ff[QUO_W-2:0]);
            end
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      divisor_ff  <= divisor_in;
      neg_ff      <= neg_in;
      quotient_ff <= quotient_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quotient_ff;

`ifndef SYNTHESIS
   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> state_ff == D_IDLE)
      else $error("divider started while busy");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == D_RUN |-> rem_ff < divisor_ff)
      else $error("partial remainder not below divisor");
`endif

endmodule
